/* rtl/core/i2cm_pkg.sv */
package i2cm_pkg;

	typedef enum logic [2:0] {
		OP_IDLE  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	localparam logic [4:0] START_LAST = 5'd3;
	localparam logic [4:0] STOP_LAST  = 5'd2;
	localparam logic [4:0] WR_ACK_REL = 5'd24;
	localparam logic [4:0] WR_ACK_SMP = 5'd25;
	localparam logic [4:0] RD_ACK_DRV = 5'd16;
	localparam logic [4:0] RD_ACK_CLK = 5'd17;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] data_byte;
		logic       send_ack;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_is_input;
		logic       busy_res;
		logic       done_res;
		logic       ack_received;
		logic [7:0] read_data;
	} result_t;

	typedef struct packed {
		logic [4:0] phase;
		op_t        cmd;
		logic [7:0] shift_byte;
		logic       ack_to_send;
		logic       ack_flag;
		logic       scl;
		logic       sda;
		logic [7:0] read_hold;
	} eng_state_t;

	typedef struct packed {
		logic [2:0] bit_pos;
		logic [1:0] sub;
	} wr_slot_t;

	// split a write phase below 24 into bit position (msb first) and sub-slot
	function automatic wr_slot_t wr_slot(input logic [4:0] p);
		wr_slot_t   r;
		logic [4:0] base;
		r.bit_pos = 3'd7;
		r.sub     = 2'd0;
		for (int i = 0; i < 8; i++) begin
			base = 5'(3 * i);
			if (p >= base) begin
				r.bit_pos = 3'(7 - i);
				r.sub     = 2'(p - base);
			end
		end
		return r;
	endfunction

endpackage

/* rtl/core/i2cm_step.sv */
module i2cm_step import i2cm_pkg::*; (
	input  eng_state_t st,
	input  item_t      item,
	output eng_state_t st_next,
	output result_t    res
);

	eng_state_t s;
	wr_slot_t   ws;
	logic       busy;
	logic       last;
	logic       rel_after;
	logic       sda_inp;
	logic [2:0] rd_bit;

	always_comb begin
		s         = st;
		busy      = 1'b0;
		last      = 1'b0;
		rel_after = 1'b0;
		sda_inp   = 1'b0;
		ws        = wr_slot(st.phase);
		rd_bit    = 3'd7 - st.phase[3:1];

		// a command is taken only while idle and runs its first slot now
		if (st.cmd == OP_IDLE && item.operation >= OP_START && item.operation <= OP_READ) begin
			s.cmd         = op_t'(item.operation);
			s.phase       = '0;
			s.shift_byte  = item.data_byte;
			s.ack_to_send = item.send_ack;
			if (item.operation == OP_READ) begin
				s.read_hold = '0;
			end
		end
		ws     = wr_slot(s.phase);
		rd_bit = 3'd7 - s.phase[3:1];

		case (s.cmd)
			OP_START: begin
				busy = 1'b1;
				if (s.phase == 5'd0) begin
					s.sda = 1'b1;
				end else if (s.phase == 5'd1) begin
					s.scl = 1'b1;
				end else if (s.phase == 5'd2) begin
					s.sda = 1'b0;
				end else begin
					s.scl = 1'b0;
					last  = 1'b1;
				end
			end
			OP_STOP: begin
				busy = 1'b1;
				if (s.phase == 5'd0) begin
					s.sda = 1'b0;
				end else if (s.phase == 5'd1) begin
					s.scl = 1'b1;
				end else begin
					s.sda = 1'b1;
					last  = 1'b1;
				end
			end
			OP_WRITE: begin
				busy = 1'b1;
				if (s.phase < WR_ACK_REL) begin
					if (ws.sub == 2'd0) begin
						s.sda = s.shift_byte[ws.bit_pos];
					end else if (ws.sub == 2'd1) begin
						s.scl = 1'b1;
					end else begin
						s.scl = 1'b0;
					end
				end else if (s.phase == WR_ACK_REL) begin
					s.sda = 1'b1;
				end else if (s.phase == WR_ACK_SMP) begin
					s.scl      = 1'b1;
					s.ack_flag = ~item.sda_in;
				end else begin
					s.scl     = 1'b0;
					rel_after = 1'b1;
					last      = 1'b1;
				end
			end
			OP_READ: begin
				busy = 1'b1;
				if (s.phase < RD_ACK_DRV) begin
					sda_inp = 1'b1;
					if (!s.phase[0]) begin
						s.scl = 1'b1;
						if (item.sda_in) begin
							s.read_hold[rd_bit] = 1'b1;
						end
					end else begin
						s.scl = 1'b0;
					end
				end else if (s.phase == RD_ACK_DRV) begin
					s.sda = ~s.ack_to_send;
				end else if (s.phase == RD_ACK_CLK) begin
					s.scl = 1'b1;
				end else begin
					s.scl     = 1'b0;
					rel_after = 1'b1;
					last      = 1'b1;
				end
			end
			default: begin
				s.cmd   = OP_IDLE;
				s.phase = '0;
			end
		endcase

		res.scl_level    = s.scl;
		res.sda_level    = s.sda;
		res.sda_is_input = sda_inp;
		res.busy_res     = busy;
		res.done_res     = last;
		res.ack_received = s.ack_flag;
		res.read_data    = s.read_hold;

		st_next = s;
		if (rel_after) begin
			st_next.sda = 1'b1;
		end
		if (busy) begin
			if (last) begin
				st_next.cmd   = OP_IDLE;
				st_next.phase = '0;
			end else begin
				st_next.phase = s.phase + 5'd1;
			end
		end
	end

endmodule

/* rtl/core/i2c_master_byte_engine_unit.sv */
// an accepted item passes through the input register, then the result register, before its result is valid
// throughput: one item per cycle while the result side is not stalled; the bus state register is updated as each item
// moves from the input register into the result register
// stalls on the result side hold both stages; no item is dropped
// reset: arst_n low clears both stages, idle command, phase 0, scl and sda released
module i2c_master_byte_engine_unit import i2cm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	output logic    cmd_ready,
	input  item_t   cmd,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	output result_t rsp
);

	item_t      item_s1;
	logic       valid_s1;
	eng_state_t st_q;
	eng_state_t st_next;
	result_t    res;
	result_t    rsp_q;
	logic       rsp_valid_q;
	logic       advance;

	i2cm_step u_step (
		.st      (st_q),
		.item    (item_s1),
		.st_next (st_next),
		.res     (res)
	);

	assign advance   = !rsp_valid_q || rsp_ready;
	assign cmd_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			st_q        <= '{phase: '0, cmd: OP_IDLE, shift_byte: '0, ack_to_send: 1'b0,
				ack_flag: 1'b0, scl: 1'b1, sda: 1'b1, read_hold: '0};
		end else begin
			if (cmd_ready) begin
				valid_s1 <= cmd_valid;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
				if (valid_s1) begin
					st_q <= st_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			item_s1 <= cmd;
		end
		if (advance && valid_s1) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* rtl/core/i2cm_checker.sv */
module i2cm_checker import i2cm_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    cmd_valid,
	input logic    cmd_ready,
	input item_t   cmd,
	input logic    rsp_valid,
	input logic    rsp_ready,
	input result_t rsp
);

	// a waiting input item holds
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
		else $error("input item changed while waiting");

	// a stalled result item holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result item changed while stalled");

	// with the result register empty the engine always takes an item
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> cmd_ready)
		else $error("input blocked with empty result register");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.done_res |-> rsp.busy_res)
		else $error("done without busy");

	// sampling slots are inside a read, never its last slot
	a_input_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.sda_is_input |-> rsp.busy_res && !rsp.done_res)
		else $error("sda input outside a read data slot");

endmodule

bind i2c_master_byte_engine_unit i2cm_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.cmd       (cmd),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

/* test/tb_i2c_master_byte_engine_unit.sv */
module tb_i2c_master_byte_engine_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cm_pkg::*;

	// operation codes outside the command set, handled as idle ticks
	localparam logic [2:0] OP_RSVD_5 = 3'd5;
	localparam logic [2:0] OP_RSVD_6 = 3'd6;
	localparam logic [2:0] OP_RSVD_7 = 3'd7;

	localparam int ITEM_TARGET = 1150;
	localparam int QUIET_AFTER = 1000;
	localparam int DRAIN_AT    = 575;

	typedef struct {
		item_t   stim;
		bit      typed;
		result_t want;
	} slot_row_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    cmd_valid;
	logic    cmd_ready;
	item_t   cmd;
	logic    rsp_valid;
	logic    rsp_ready;
	result_t rsp;

	i2c_master_byte_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// bus engine mirror
	logic [4:0] eng_phase;
	op_t        eng_cmd;
	logic [7:0] eng_shift;
	logic       eng_ack_tx;
	logic       eng_ack_seen;
	logic       eng_scl;
	logic       eng_sda;
	logic [7:0] eng_rd_byte;

	result_t     bus_slots_due[$];
	slot_row_t   directed_slots[$];
	int          errors = 0;
	int          sent = 0;
	int          results_seen = 0;
	bit          quiet = 1'b0;
	int unsigned tx_rate = 0;
	int unsigned rx_rate = 0;
	int          rx_stall = 0;
	int          rx_cycle = 0;

	task automatic report_mismatch(input string msg);
		$display("mismatch at result %0d: %s", results_seen, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	function automatic int unsigned pick_rate();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 8;
			default: return 25;
		endcase
	endfunction

	// bytes lean toward all zeros and all ones
	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic result_t levels(input logic scl, input logic sda, input logic busy,
			input logic done);
		result_t r;
		r = '0;
		r.scl_level = scl;
		r.sda_level = sda;
		r.busy_res  = busy;
		r.done_res  = done;
		return r;
	endfunction

	// advance the engine by one delay slot and return what the slot shows
	function automatic result_t step_bus(input item_t it);
		result_t    r;
		logic [4:0] p;
		logic [2:0] bpos;
		logic       sda_dir;
		logic       busy;
		logic       last;
		logic       rel;
		sda_dir = 1'b0;
		busy    = 1'b0;
		last    = 1'b0;
		rel     = 1'b0;
		if (eng_cmd == OP_IDLE && it.operation >= OP_START
				&& it.operation <= OP_READ) begin
			eng_cmd    = op_t'(it.operation);
			eng_phase  = '0;
			eng_shift  = it.data_byte;
			eng_ack_tx = it.send_ack;
			if (eng_cmd == OP_READ)
				eng_rd_byte = '0;
		end
		p = eng_phase;
		case (eng_cmd)
			OP_START: begin
				busy = 1'b1;
				if (p == 0)
					eng_sda = 1'b1;
				else if (p == 1)
					eng_scl = 1'b1;
				else if (p == 2)
					eng_sda = 1'b0;
				else begin
					eng_scl = 1'b0;
					last = 1'b1;
				end
			end
			OP_STOP: begin
				busy = 1'b1;
				if (p == 0)
					eng_sda = 1'b0;
				else if (p == 1)
					eng_scl = 1'b1;
				else begin
					eng_sda = 1'b1;
					last = 1'b1;
				end
			end
			OP_WRITE: begin
				busy = 1'b1;
				if (p < WR_ACK_REL) begin
					bpos = 3'(7 - p / 3);
					case (p % 3)
						0: eng_sda = eng_shift[bpos];
						1: eng_scl = 1'b1;
						default: eng_scl = 1'b0;
					endcase
				end else if (p == WR_ACK_REL) begin
					eng_sda = 1'b1;
				end else if (p == WR_ACK_SMP) begin
					eng_scl = 1'b1;
					eng_ack_seen = !it.sda_in;
				end else begin
					eng_scl = 1'b0;
					rel = 1'b1;
					last = 1'b1;
				end
			end
			OP_READ: begin
				busy = 1'b1;
				if (p < RD_ACK_DRV) begin
					bpos = 3'(7 - p / 2);
					sda_dir = 1'b1;
					if (!p[0]) begin
						eng_scl = 1'b1;
						if (it.sda_in)
							eng_rd_byte[bpos] = 1'b1;
					end else begin
						eng_scl = 1'b0;
					end
				end else if (p == RD_ACK_DRV) begin
					eng_sda = !eng_ack_tx;
				end else if (p == RD_ACK_CLK) begin
					eng_scl = 1'b1;
				end else begin
					eng_scl = 1'b0;
					rel = 1'b1;
					last = 1'b1;
				end
			end
			default: begin
				eng_cmd = OP_IDLE;
				eng_phase = '0;
			end
		endcase
		r.scl_level    = eng_scl;
		r.sda_level    = eng_sda;
		r.sda_is_input = sda_dir;
		r.busy_res     = busy;
		r.done_res     = last;
		r.ack_received = eng_ack_seen;
		r.read_data    = eng_rd_byte;
		if (rel)
			eng_sda = 1'b1;
		if (busy) begin
			if (last) begin
				eng_cmd = OP_IDLE;
				eng_phase = '0;
			end else begin
				eng_phase = p + 5'd1;
			end
		end
		return r;
	endfunction

	function automatic void add_row(input logic [2:0] op, input logic [7:0] data,
			input logic ack, input logic sda, input bit typed, input result_t want);
		slot_row_t row;
		row.stim.operation = op;
		row.stim.data_byte = data;
		row.stim.send_ack  = ack;
		row.stim.sda_in    = sda;
		row.typed          = typed;
		row.want           = want;
		directed_slots.push_back(row);
	endfunction

	task automatic send_item(input item_t it, input bit typed, input result_t want);
		result_t predicted;
		if (!quiet && $urandom_range(0, 99) < tx_rate) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat ($urandom_range(0, 13)) @(negedge clk);
		end
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd <= it;
		do @(posedge clk); while (!cmd_ready);
		predicted = step_bus(it);
		bus_slots_due.push_back(typed ? want : predicted);
		sent++;
		if (sent % 128 == 0)
			tx_rate = pick_rate();
		quiet = sent >= QUIET_AFTER;
	endtask

	// one command and the rest of its slots, with noise on the ignored fields
	task automatic run_command(input logic [2:0] op, input logic [7:0] data,
			input logic ack_tx, input logic [7:0] rd_pattern, input logic ack_in);
		int         n;
		item_t      it;
		logic [4:0] p;
		case (op)
			OP_START: n = START_LAST + 1;
			OP_STOP:  n = STOP_LAST + 1;
			OP_WRITE: n = WR_ACK_SMP + 2;
			OP_READ:  n = RD_ACK_CLK + 2;
			default:  n = 1;
		endcase
		for (int s = 0; s < n; s++) begin
			p = 5'(s);
			if (s == 0) begin
				it.operation = op;
				it.data_byte = data;
				it.send_ack  = ack_tx;
			end else begin
				it.operation = ($urandom_range(0, 3) == 0) ?
					3'($urandom_range(0, 7)) : OP_IDLE;
				it.data_byte = 8'($urandom);
				it.send_ack  = 1'($urandom);
			end
			it.sda_in = 1'($urandom);
			if (op == OP_WRITE && p == WR_ACK_SMP)
				it.sda_in = ack_in;
			if (op == OP_READ && p < RD_ACK_DRV && !p[0])
				it.sda_in = rd_pattern[3'(7 - s / 2)];
			send_item(it, 1'b0, '0);
		end
	endtask

	task automatic run_random(input logic [2:0] op);
		run_command(op, rand_byte(), 1'($urandom), rand_byte(), 1'($urandom));
	endtask

	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 128 == 0)
			rx_rate = pick_rate();
		if (rx_stall > 0) begin
			rsp_ready <= 1'b0;
			rx_stall--;
		end else if (!quiet && $urandom_range(0, 99) < rx_rate) begin
			rsp_ready <= 1'b0;
			rx_stall = $urandom_range(0, 13);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (bus_slots_due.size() == 0) begin
				report_mismatch("result with nothing pending");
			end else begin
				want = bus_slots_due.pop_front();
				check_field("scl_level", 8'(rsp.scl_level), 8'(want.scl_level));
				check_field("sda_level", 8'(rsp.sda_level), 8'(want.sda_level));
				check_field("sda_is_input", 8'(rsp.sda_is_input),
					8'(want.sda_is_input));
				check_field("busy_res", 8'(rsp.busy_res), 8'(want.busy_res));
				check_field("done_res", 8'(rsp.done_res), 8'(want.done_res));
				check_field("ack_received", 8'(rsp.ack_received),
					8'(want.ack_received));
				check_field("read_data", rsp.read_data, want.read_data);
			end
			results_seen++;
		end
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int  pick;
		bit  drained;
		drained      = 1'b0;
		arst_n       = 1'b0;
		cmd_valid    = 1'b0;
		cmd          = '0;
		rsp_ready    = 1'b0;
		eng_phase    = '0;
		eng_cmd      = OP_IDLE;
		eng_shift    = '0;
		eng_ack_tx   = 1'b0;
		eng_ack_seen = 1'b0;
		eng_scl      = 1'b1;
		eng_sda      = 1'b1;
		eng_rd_byte  = '0;

		// commands issued while busy are ignored; reserved codes act as idle ticks
		add_row(OP_IDLE,   8'h00, 1'b0, 1'b0, 1'b1, levels(1'b1, 1'b1, 1'b0, 1'b0));
		add_row(OP_RSVD_5, 8'hff, 1'b1, 1'b1, 1'b1, levels(1'b1, 1'b1, 1'b0, 1'b0));
		add_row(OP_RSVD_7, 8'h00, 1'b1, 1'b0, 1'b1, levels(1'b1, 1'b1, 1'b0, 1'b0));
		add_row(OP_START,  8'hff, 1'b1, 1'b1, 1'b1, levels(1'b1, 1'b1, 1'b1, 1'b0));
		add_row(OP_READ,   8'h00, 1'b1, 1'b0, 1'b1, levels(1'b1, 1'b1, 1'b1, 1'b0));
		add_row(OP_WRITE,  8'hff, 1'b0, 1'b1, 1'b1, levels(1'b1, 1'b0, 1'b1, 1'b0));
		add_row(OP_STOP,   8'h00, 1'b0, 1'b0, 1'b1, levels(1'b0, 1'b0, 1'b1, 1'b1));
		add_row(OP_IDLE,   8'hff, 1'b1, 1'b1, 1'b1, levels(1'b0, 1'b0, 1'b0, 1'b0));
		add_row(OP_STOP,   8'h00, 1'b1, 1'b0, 1'b1, levels(1'b0, 1'b0, 1'b1, 1'b0));
		add_row(OP_START,  8'hff, 1'b1, 1'b1, 1'b1, levels(1'b1, 1'b0, 1'b1, 1'b0));
		add_row(OP_RSVD_6, 8'h00, 1'b0, 1'b0, 1'b1, levels(1'b1, 1'b1, 1'b1, 1'b1));
		add_row(OP_RSVD_7, 8'hff, 1'b0, 1'b1, 1'b1, levels(1'b1, 1'b1, 1'b0, 1'b0));
		add_row(OP_START,  8'h5a, 1'b0, 1'b0, 1'b0, '0);
		add_row(OP_WRITE,  8'ha5, 1'b1, 1'b1, 1'b0, '0);
		add_row(OP_IDLE,   8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_row(OP_READ,   8'hff, 1'b1, 1'b1, 1'b0, '0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_slots[i])
			send_item(directed_slots[i].stim, directed_slots[i].typed, directed_slots[i].want);

		// extremes of write and read with both ack outcomes
		run_command(OP_WRITE, 8'hff, 1'b0, 8'h00, 1'b0);
		run_command(OP_WRITE, 8'h00, 1'b1, 8'h00, 1'b1);
		run_command(OP_READ,  8'h00, 1'b1, 8'hff, 1'b0);
		run_command(OP_READ,  8'hff, 1'b0, 8'h00, 1'b1);
		run_command(OP_STOP,  8'h00, 1'b0, 8'h00, 1'b0);

		while (sent < ITEM_TARGET) begin
			if (!drained && sent >= DRAIN_AT) begin
				drained = 1'b1;
				@(negedge clk);
				cmd_valid <= 1'b0;
				while (bus_slots_due.size() != 0) @(negedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				run_random(OP_IDLE);
			end else if (pick < 10) begin
				run_random(3'($urandom_range(OP_RSVD_5, OP_RSVD_7)));
			end else if (pick < 20) begin
				run_random(3'($urandom_range(OP_START, OP_READ)));
			end else begin
				// a bus transaction, now and then without its stop
				run_random(OP_START);
				repeat ($urandom_range(1, 4))
					run_random($urandom_range(0, 1) ? OP_WRITE : OP_READ);
				if ($urandom_range(0, 9) != 0)
					run_random(OP_STOP);
			end
		end

		@(negedge clk);
		cmd_valid <= 1'b0;
		while (bus_slots_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
